### rtl/core/ibb32_pkg.sv
// Shared types, constants and helpers of the inverted-byte base32 encoder.
// No dependencies; every other file of the block imports this package.
package ibb32_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned GROUP_W  = 5;
	localparam int unsigned SYMBOL_W = 7;
	localparam int unsigned RES_W    = 4;   // residue bits held between bytes
	localparam int unsigned RCNT_W   = 3;   // residue count, 0 to 4
	localparam int unsigned MAX_SYMS = 3;   // characters one byte can produce
	localparam int unsigned SCNT_W   = 2;   // holds 1 to MAX_SYMS

	localparam logic [BYTE_W-1:0]   INVERT_MASK  = 8'hFF;
	localparam logic [RCNT_W-1:0]   RES_MAX      = 3'd4;
	localparam logic [GROUP_W-1:0]  LETTER_COUNT = 5'd26;
	localparam logic [SYMBOL_W-1:0] ASCII_A      = 7'd65;
	// '2' is ASCII 50 and stands for group 26, so the offset is 50 - 26
	localparam logic [SYMBOL_W-1:0] DIGIT_BASE   = 7'd24;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last_symbol;
	} out_item_t;

	// One byte's worth of work: its groups in emission order
	typedef struct packed {
		logic [MAX_SYMS-1:0][GROUP_W-1:0] groups;   // index 0 goes out first
		logic [SCNT_W-1:0]                sym_count;
		logic                             end_of_message;
	} work_t;

	function automatic logic [SYMBOL_W-1:0] group_to_ascii(input logic [GROUP_W-1:0] grp);
		logic [SYMBOL_W-1:0] wide;
		wide = {2'b00, grp};
		if (grp < LETTER_COUNT) begin
			return ASCII_A + wide;
		end else begin
			return DIGIT_BASE + wide;
		end
	endfunction

endpackage

### rtl/core/inverted_byte_base32_encoder_unit.sv
// Top level of the inverted-byte base32 encoder (RFC 4648 alphabet, no padding).
// Instantiates ibb32_front, ibb32_queue and ibb32_back; depends on ibb32_pkg.
//
// Usage:
//   Input queue side: drive byte_item and raise push; a byte is taken at a
//   clock edge with push high and full low. Set end_of_message on the last
//   byte of a message to flush the leftover bits as a final character.
//   Result queue side: while empty is low, symbol_item holds the oldest
//   character; take it with pop. last_symbol marks a message's final char.
//   Each byte yields one to three characters, one per cycle out as pops allow.
//   A byte's first character passes the work queue, then the result register.
//   Throughput: the result register emits one character a clock while the
//   receiver pops; the front end takes a byte each cycle while the work
//   queue (QUEUE_DEPTH entries) has room.
//   When the receiver stalls, the result holds, the queue fills and full
//   rises; nothing is dropped.
//   Reset (arst_n low) empties the queue and result register and clears
//   the residue, starting a fresh message.
module inverted_byte_base32_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  ibb32_pkg::in_item_t  byte_item,
	input  logic                 pop,
	output logic                 empty,
	output ibb32_pkg::out_item_t symbol_item
);
	import ibb32_pkg::*;

	logic  accept;
	work_t front_work;
	work_t head_work;
	logic  queue_empty;
	logic  head_done;

	// take a byte only while the work queue has room
	assign accept = push && !full;

	ibb32_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_item),
		.work   (front_work)
	);

	ibb32_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_work),
		.rd_en   (head_done),
		.rd_data (head_work),
		.full    (full),
		.empty   (queue_empty)
	);

	// advance through the head entry, drop it after its last group
	ibb32_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_work),
		.head_valid (!queue_empty),
		.head_done  (head_done),
		.pop        (pop),
		.empty      (empty),
		.result     (symbol_item)
	);

endmodule

### rtl/core/ibb32_front.sv
// Front end: inverts each accepted byte, splits it with the residue into 5-bit groups.
// Holds the residue between bytes. Depends on ibb32_pkg.
module ibb32_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ibb32_pkg::in_item_t item,
	output ibb32_pkg::work_t   work
);
	import ibb32_pkg::*;

	logic [RES_W-1:0]   residue_bits_q;
	logic [RCNT_W-1:0]  residue_count_q;
	logic [RCNT_W-1:0]  cnt;
	logic [BYTE_W-1:0]  inv_byte;
	logic [14:0]        window;
	logic [RCNT_W-1:0]  left_shift;
	logic               two_full;
	logic               flush;
	logic [RCNT_W-1:0]  next_count;
	logic [RES_W:0]     keep_mask;

	always_comb begin
		cnt        = (residue_count_q > RES_MAX) ? RES_MAX : residue_count_q;
		inv_byte   = item.data_byte ^ INVERT_MASK;
		left_shift = RES_MAX - cnt;
		// Left-align the valid bits at the top of the window, zero fill below
		window     = {residue_bits_q, inv_byte, 3'b000} << left_shift;
		two_full   = (cnt >= 3'd2);
		// Leftover after the full groups is cnt-2 or cnt+3 bits
		next_count = two_full ? (cnt - 3'd2) : (cnt + 3'd3);
		flush      = item.end_of_message && (next_count != '0);
		keep_mask  = (5'd1 << next_count) - 5'd1;

		work.groups[0]      = window[14:10];
		work.groups[1]      = window[9:5];
		work.groups[2]      = window[4:0];
		work.sym_count      = (two_full ? 2'd2 : 2'd1) + {1'b0, flush};
		work.end_of_message = item.end_of_message;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_bits_q  <= '0;
			residue_count_q <= '0;
		end else if (accept) begin
			if (item.end_of_message) begin
				residue_bits_q  <= '0;
				residue_count_q <= '0;
			end else begin
				residue_bits_q  <= inv_byte[RES_W-1:0] & keep_mask[RES_W-1:0];
				residue_count_q <= next_count;
			end
		end
	end

`ifndef ASSERT_OFF
	a_res_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		residue_count_q <= RES_MAX)
		else $error("residue count out of range");
	a_res_clears_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.end_of_message |=> residue_count_q == '0 && residue_bits_q == '0)
		else $error("residue not cleared after final byte");
	a_unused_res_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(residue_bits_q & ~((4'd1 << residue_count_q) - 4'd1)) == '0)
		else $error("residue holds bits above its count");
`endif
endmodule

### rtl/core/ibb32_queue.sv
// Short work queue between the front and back ends of the base32 encoder.
// Circular buffer of work_t entries; depends on ibb32_pkg.
module ibb32_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ibb32_pkg::work_t wr_data,
	input  logic             rd_en,
	output ibb32_pkg::work_t rd_data,
	output logic             full,
	output logic             empty
);
	import ibb32_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	work_t             entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full) && !(rd_en && empty))
		else $error("queue written when full or read when empty");
`endif
endmodule

### rtl/core/ibb32_back.sv
// Back end: walks the head work entry one group per cycle into the result register
// while it is free or popped. Maps groups to base32 ASCII; depends on ibb32_pkg.
module ibb32_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ibb32_pkg::work_t      head,
	input  logic                  head_valid,
	output logic                  head_done,
	input  logic                  pop,
	output logic                  empty,
	output ibb32_pkg::out_item_t  result
);
	import ibb32_pkg::*;

	logic [SCNT_W-1:0] idx_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              load;
	logic              at_end;

	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign load      = head_valid && (!out_valid_q || pop);
	assign at_end    = (idx_q == head.sym_count - 2'd1);
	assign head_done = load && at_end;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.symbol      <= group_to_ascii(head.groups[idx_q]);
			out_q.last_symbol <= head.end_of_message && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_idx_within_entry: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head.sym_count)
		else $error("group index beyond entry");
	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == '0)
		else $error("group index left mid-entry with queue empty");
`endif
endmodule
